// ----- hw/rtl/ghs_pkg.sv -----
// ----------------------------------------------------------------------------
// ghs_pkg
// Shared constants, codes and types of the generational handle sparse set.
// ----------------------------------------------------------------------------
package ghs_pkg;

	localparam int MAX_HANDLES = 1024;
	localparam int GEN_BITS    = 16;
	localparam int IDX_W       = $clog2(MAX_HANDLES);
	localparam int CNT_W       = $clog2(MAX_HANDLES + 1);

	localparam logic [1:0] MODE_CREATE  = 2'd0;
	localparam logic [1:0] MODE_DESTROY = 2'd1;
	localparam logic [1:0] MODE_LOOKUP  = 2'd2;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_STALE = 2'd2;

	typedef struct packed {
		logic [IDX_W-1:0]    idx;
		logic [GEN_BITS-1:0] gen;
	} handle_t;

	typedef struct packed {
		logic                alive;
		logic [GEN_BITS-1:0] gen;
	} meta_t;

	// controller -> datapath
	typedef struct packed {
		logic cap;     // take request word, launch memory reads
		logic commit;  // write back and load result register
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_stall;  // result register still held by the sink
	} ctrl_sts_t;

endpackage

// ----- hw/rtl/ghs_ctrl.sv -----
// ----------------------------------------------------------------------------
// ghs_ctrl
// Two-state sequencer: capture a request word, then commit it.
// ----------------------------------------------------------------------------
module ghs_ctrl import ghs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   in_ready_q;

	assign in_ready   = in_ready_q;
	assign cmd.cap    = in_valid && in_ready_q;
	assign cmd.commit = (state_q == ST_EXEC) && !sts.out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.cap) begin
						state_q    <= ST_EXEC;
						in_ready_q <= 1'b0;
					end
				end
				ST_EXEC: begin
					if (cmd.commit) begin
						state_q    <= ST_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/ghs_datapath.sv -----
// ----------------------------------------------------------------------------
// ghs_datapath
// Sparse, dense and free-stack memories, counters and the result register.
// ----------------------------------------------------------------------------
module ghs_datapath import ghs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  ctrl_cmd_t           cmd,
	output ctrl_sts_t           sts,
	input  logic [1:0]          mode,
	input  logic [IDX_W-1:0]    handle_index,
	input  logic [GEN_BITS-1:0] handle_generation,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [IDX_W-1:0]    out_index,
	output logic [GEN_BITS-1:0] out_generation,
	output logic [IDX_W-1:0]    dense_slot,
	output logic [CNT_W-1:0]    live_count
);

	// memories
	meta_t            meta_mem  [MAX_HANDLES];
	logic [IDX_W-1:0] slot_mem  [MAX_HANDLES];
	handle_t          dense_mem [MAX_HANDLES];
	handle_t          free_mem  [MAX_HANDLES];

	// request word and read data
	logic [1:0]          mode_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [GEN_BITS-1:0] gen_s1;
	meta_t               meta_rd_s1;
	logic [IDX_W-1:0]    slot_rd_s1;
	handle_t             free_rd_s1;
	handle_t             dense_rd_s1;

	// counters
	logic [CNT_W-1:0] live_q;
	logic [CNT_W-1:0] free_q;
	logic [CNT_W-1:0] hwm_q;   // indices ever handed out

	// result register
	logic                out_valid_q;
	logic [1:0]          status_q;
	logic [IDX_W-1:0]    out_index_q;
	logic [GEN_BITS-1:0] out_gen_q;
	logic [IDX_W-1:0]    dense_slot_q;
	logic [CNT_W-1:0]    live_count_q;

	logic [IDX_W-1:0]    free_rd_addr;
	logic [IDX_W-1:0]    dense_rd_addr;
	logic                is_create;
	logic                is_destroy;
	logic                alive;
	logic                hnd_ok;
	logic                pop;
	logic                full;
	logic                do_create;
	logic                do_destroy;
	logic [IDX_W-1:0]    c_idx;
	logic [GEN_BITS-1:0] c_gen;
	logic [GEN_BITS-1:0] gen_base;
	logic [IDX_W-1:0]    live_idx;

	// reads go out on the capture edge: top of stack and last dense entry
	assign free_rd_addr  = IDX_W'(free_q - CNT_W'(1));
	assign dense_rd_addr = IDX_W'(live_q - CNT_W'(1));

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			mode_s1     <= mode;
			idx_s1      <= handle_index;
			gen_s1      <= handle_generation;
			meta_rd_s1  <= meta_mem[handle_index];
			slot_rd_s1  <= slot_mem[handle_index];
			free_rd_s1  <= free_mem[free_rd_addr];
			dense_rd_s1 <= dense_mem[dense_rd_addr];
		end
	end

	// decode and handle check; entries at or above the high-water mark were
	// never written, so their alive bit is forced off
	assign is_create  = (mode_s1 == MODE_CREATE);
	assign is_destroy = (mode_s1 == MODE_DESTROY);
	assign alive      = meta_rd_s1.alive && (CNT_W'(idx_s1) < hwm_q);
	assign hnd_ok     = alive && (meta_rd_s1.gen == gen_s1);
	assign pop        = (free_q != '0);
	assign full       = !pop && (live_q == CNT_W'(MAX_HANDLES));
	assign do_create  = cmd.commit && is_create && !full;
	assign do_destroy = cmd.commit && is_destroy && hnd_ok;
	assign live_idx   = IDX_W'(live_q);
	assign c_idx      = pop ? free_rd_s1.idx : live_idx;
	assign gen_base   = pop ? free_rd_s1.gen : '0;
	assign c_gen      = gen_base + GEN_BITS'(1);

	// write-back
	always_ff @(posedge clk) begin
		if (do_create) begin
			meta_mem[c_idx]     <= '{alive: 1'b1, gen: c_gen};
			slot_mem[c_idx]     <= live_idx;
			dense_mem[live_idx] <= '{idx: c_idx, gen: c_gen};
		end else if (do_destroy) begin
			meta_mem[idx_s1]          <= '{alive: 1'b0, gen: gen_s1};
			slot_mem[dense_rd_s1.idx] <= slot_rd_s1;   // last entry moves in
			dense_mem[slot_rd_s1]     <= dense_rd_s1;
			free_mem[IDX_W'(free_q)]  <= '{idx: idx_s1, gen: gen_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			free_q <= '0;
			hwm_q  <= '0;
		end else if (do_create) begin
			live_q <= live_q + CNT_W'(1);
			if (pop) begin
				free_q <= free_q - CNT_W'(1);
			end else begin
				hwm_q <= hwm_q + CNT_W'(1);
			end
		end else if (do_destroy) begin
			live_q <= live_q - CNT_W'(1);
			free_q <= free_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (is_create) begin
				if (full) begin
					status_q     <= STATUS_FULL;
					out_index_q  <= '0;
					out_gen_q    <= '0;
					dense_slot_q <= '0;
					live_count_q <= live_q;
				end else begin
					status_q     <= STATUS_OK;
					out_index_q  <= c_idx;
					out_gen_q    <= c_gen;
					dense_slot_q <= live_idx;
					live_count_q <= live_q + CNT_W'(1);
				end
			end else if (!hnd_ok) begin
				status_q     <= STATUS_STALE;
				out_index_q  <= idx_s1;
				out_gen_q    <= gen_s1;
				dense_slot_q <= '0;
				live_count_q <= live_q;
			end else begin
				status_q     <= STATUS_OK;
				out_index_q  <= idx_s1;
				out_gen_q    <= gen_s1;
				dense_slot_q <= slot_rd_s1;
				live_count_q <= is_destroy ? live_q - CNT_W'(1) : live_q;
			end
		end
	end

	assign sts.out_stall  = out_valid_q && !out_ready;
	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign out_index      = out_index_q;
	assign out_generation = out_gen_q;
	assign dense_slot     = dense_slot_q;
	assign live_count     = live_count_q;

	// every handed-out index is either live or on the free stack
	a_count_balance: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, live_q} + {1'b0, free_q}) == {1'b0, hwm_q})
		else $error("live plus free count differs from high-water mark");

	a_hwm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hwm_q <= CNT_W'(MAX_HANDLES))
		else $error("high-water mark beyond table size");

	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.commit))
		else $error("result word appeared without a commit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("commit overwrote an untaken result word");

endmodule

// ----- hw/rtl/generational_handle_sparse_set_unit.sv -----
// ----------------------------------------------------------------------------
// generational_handle_sparse_set_unit
// Create / destroy / look up of generational handles kept in a sparse set.
// ----------------------------------------------------------------------------
// Capture: a request word is registered with the reads of the sparse, dense and
//   free-stack memories. Commit: write-back and result register load, held while
//   the result register is still occupied; no new word is taken before the commit.
// Reset: counters and the result valid flag clear at once; no clearing pass.
//   Alive marks at or above the high-water index count read as dead.
// ----------------------------------------------------------------------------
module generational_handle_sparse_set_unit import ghs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// request channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          mode,
	input  logic [IDX_W-1:0]    handle_index,
	input  logic [GEN_BITS-1:0] handle_generation,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [IDX_W-1:0]    out_index,
	output logic [GEN_BITS-1:0] out_generation,
	output logic [IDX_W-1:0]    dense_slot,
	output logic [CNT_W-1:0]    live_count
);

	// Sequencer tells the datapath when to capture a word and when to
	// commit it; the datapath reports back whether the result register
	// is still occupied, which holds the commit.
	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	ghs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: memories, live/free/high-water counters, result register.
	// The result register decouples the sink, so a new word may be taken
	// while the previous result still waits.
	ghs_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.mode              (mode),
		.handle_index      (handle_index),
		.handle_generation (handle_generation),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.status            (status),
		.out_index         (out_index),
		.out_generation    (out_generation),
		.dense_slot        (dense_slot),
		.live_count        (live_count)
	);

endmodule
